[hw/rtl/rational_arithmetic_unit_assert.svh]
// assertion macros for the rational arithmetic unit
// depends on nothing; checks drop out when SYNTHESIS is defined
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[hw/rtl/rau_pkg.sv]
// shared types and constants for the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package rau_pkg;
    localparam int W = 64;
    localparam int CW = 7;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_CMP = 3'd4, OP_RCP = 3'd5, OP_NEG = 3'd6, OP_BAD = 3'd7
    } op_t;

    // serial multiplier / divider control
    typedef enum logic [1:0] {
        SU_IDLE, SU_MUL, SU_DIV
    } su_state_t;

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_W1, S_M2, S_W2, S_M3, S_W3, S_SUM, S_CHK,
        S_GCD, S_GW, S_GSW, S_DN, S_DNW, S_DD, S_DDW, S_FIX, S_DONE
    } state_t;

    typedef struct packed {
        logic mul;
        logic div;
    } su_cmd_t;
endpackage

[hw/rtl/rau_serial.sv]
// bit-serial unsigned multiplier and divider, one bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_assert.svh"
module rau_serial
    import rau_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  su_cmd_t        cmd,
    input  logic [W-1:0]   x,
    input  logic [W-1:0]   y,
    output logic           done,
    output logic [2*W-1:0] prod,
    output logic [W-1:0]   quo,
    output logic [W-1:0]   rem
);
    su_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [2*W-1:0] acc_reg;
    logic [W-1:0] sh_reg;
    logic [W-1:0] y_reg;
    logic [W:0]   r_try;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SU_IDLE:
            begin
                if (cmd.mul) state_next = SU_MUL;
                else if (cmd.div) state_next = SU_DIV;
            end
            SU_MUL, SU_DIV:
            begin
                if (cnt_reg == CW'(W - 1)) state_next = SU_IDLE;
            end
            default: state_next = SU_IDLE;
        endcase
    end

    // restoring division step on the high half of acc
    assign r_try = {acc_reg[2*W-2:W-1], sh_reg[W-1]} - {1'b0, y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SU_IDLE;
            cnt_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg != SU_IDLE) && (cnt_reg == CW'(W - 1));
            if (state_reg == SU_IDLE) cnt_reg <= '0;
            else cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SU_IDLE:
            begin
                acc_reg <= '0;
                sh_reg  <= x;
                y_reg   <= y;
            end
            SU_MUL:
            begin
                // shift-add from the msb of the multiplier
                acc_reg <= {acc_reg[2*W-2:0], 1'b0}
                    + (sh_reg[W-1] ? {{W{1'b0}}, y_reg} : '0);
                sh_reg  <= {sh_reg[W-2:0], 1'b0};
            end
            SU_DIV:
            begin
                if (!r_try[W])
                begin
                    acc_reg[2*W-1:W-1] <= {1'b0, r_try[W-1:0]};
                    sh_reg <= {sh_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_reg[2*W-1:W-1] <= {1'b0, acc_reg[2*W-3:W-1], sh_reg[W-1]};
                    sh_reg <= {sh_reg[W-2:0], 1'b0};
                end
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    assign prod = acc_reg;
    assign quo  = sh_reg;
    assign rem  = acc_reg[2*W-2:W-1];

    `RAU_ASSERT(a_cmd_idle, clk, rst_n, (cmd.mul || cmd.div) |-> state_reg == SU_IDLE, "busy cmd")
    `RAU_ASSERT(a_cmd_one, clk, rst_n, !(cmd.mul && cmd.div), "two cmds")
    `RAU_ASSERT_NEXT(a_done, clk, rst_n, done, state_reg == SU_IDLE, "done mid-op")
endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// top level of the rational arithmetic unit: sequencer around a serial mul/div
// depends on rau_pkg and rau_serial
`timescale 1ns / 1ps
//
// usage: drive op and both operands and pulse start while busy is low; the
// request is taken at that edge and busy rises. when the work ends, done
// pulses for one cycle with res_num, res_den, res_ok and cmp_diff valid in
// that cycle only; the receiver cannot stall and must capture it then.
// sequence: each product runs on the shared one-bit-per-cycle multiplier
// (three for add and subtract, two for the other binary ops), each
// remainder of the euclidean gcd runs on the same unit's divider, plus
// two final divisions. the loop count of the gcd sets the spread: negate and
// the unknown op go straight to done, and the longest gcd chains take the
// longest. one request at a time; busy is low again in the done cycle, so
// the next request can be taken there.
// reset: async active low, returns to idle with busy and done low.
//
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [2:0]         op,
    input  logic signed [63:0] a_num,
    input  logic signed [63:0] a_den,
    input  logic               a_ok,
    input  logic signed [63:0] b_num,
    input  logic signed [63:0] b_den,
    input  logic               b_ok,
    output logic signed [63:0] res_num,
    output logic signed [63:0] res_den,
    output logic               res_ok,
    output logic signed [63:0] cmp_diff
);
    state_t state_reg, state_next;
    op_t    op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] p_reg, q_reg, d_reg;   // products
    logic [W-1:0] ga_reg, gb_reg;        // gcd operands
    logic [W-1:0] num_reg, den_reg;
    logic         ok_reg;
    logic         a_ok_reg;              // validity for the unary ops, which ignore b_ok
    logic [1:0]   mi_reg;                // which product

    su_cmd_t        cmd;
    logic [W-1:0]   sx, sy;
    logic           sdone;
    logic [2*W-1:0] prod;
    logic [W-1:0]   quo, rem;

    rau_serial u_serial (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .x(sx), .y(sy), .done(sdone),
        .prod(prod), .quo(quo), .rem(rem)
    );

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (W'(0) - v) : v;
    endfunction

    // operands of the current product
    // first: numerator or left cross product, second: denominator or right
    // cross product, third: common denominator of add and subtract
    logic [W-1:0] ma, mb;
    always_comb
    begin
        ma = an_reg;
        mb = bd_reg;
        unique case (mi_reg)
            2'd0:
            begin
                ma = an_reg;
                mb = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                ma = ad_reg;
                mb = (op_reg == OP_MUL) ? bd_reg : bn_reg;
            end
            2'd2:
            begin
                ma = ad_reg;
                mb = bd_reg;
            end
            default:
            begin
                ma = ad_reg;
                mb = bd_reg;
            end
        endcase
    end

    // signed product check from the unsigned magnitude product
    logic         pneg;
    logic [W-1:0] pval;
    logic         pov;
    always_comb
    begin
        pneg = ma[W-1] ^ mb[W-1];
        pval = pneg ? (W'(0) - prod[W-1:0]) : prod[W-1:0];
        if (prod[2*W-1:W] != '0) pov = 1'b1;
        else if (pneg) pov = prod[W-1] && (prod[W-2:0] != '0);
        else pov = prod[W-1];
    end

    // sum or difference of the two cross products
    logic [W-1:0] sum;
    logic         sov;
    always_comb
    begin
        if (op_reg == OP_ADD)
        begin
            sum = p_reg + q_reg;
            sov = (p_reg[W-1] == q_reg[W-1]) && (sum[W-1] != p_reg[W-1]);
        end
        else
        begin
            sum = p_reg - q_reg;
            sov = (p_reg[W-1] != q_reg[W-1]) && (sum[W-1] != p_reg[W-1]);
        end
    end

    logic last_mul;
    assign last_mul = (op_reg == OP_ADD || op_reg == OP_SUB) ? (mi_reg == 2'd2)
        : (mi_reg == 2'd1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_M1;
            S_M1:
            begin
                priority if (op_reg == OP_NEG || op_reg == OP_BAD) state_next = S_DONE;
                else if (op_reg == OP_RCP) state_next = S_CHK;
                else state_next = S_W1;
            end
            S_W1:
            begin
                if (sdone) state_next = last_mul ? S_SUM : S_M1;
            end
            S_SUM:
            begin
                priority if (op_reg == OP_CMP) state_next = S_DONE;
                else state_next = S_CHK;
            end
            S_CHK:
            begin
                if (num_reg == '0 && den_reg == '0) state_next = S_DONE;
                else state_next = S_GCD;
            end
            S_GCD: state_next = (gb_reg == '0) ? S_DN : S_GW;
            S_GW:  if (sdone) state_next = S_GCD;
            S_DN:  state_next = S_DNW;
            S_DNW: if (sdone) state_next = S_DD;
            S_DD:  state_next = S_DDW;
            S_DDW: if (sdone) state_next = S_FIX;
            S_FIX: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        sx  = ga_reg;
        sy  = gb_reg;
        unique case (state_reg)
            S_M1:
            begin
                cmd.mul = (op_reg != OP_NEG) && (op_reg != OP_BAD) && (op_reg != OP_RCP);
                sx = mag(ma);
                sy = mag(mb);
            end
            S_GCD:
            begin
                cmd.div = (gb_reg != '0);
            end
            S_DN:
            begin
                cmd.div = 1'b1;
                sx = mag(num_reg);
                sy = ga_reg;
            end
            S_DD:
            begin
                cmd.div = 1'b1;
                sx = mag(den_reg);
                sy = ga_reg;
            end
            default: cmd = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_reg   <= op_t'(op);
                    an_reg   <= a_num;
                    ad_reg   <= a_den;
                    bn_reg   <= b_num;
                    bd_reg   <= b_den;
                    ok_reg   <= a_ok && b_ok;
                    a_ok_reg <= a_ok;
                    mi_reg   <= '0;
                    num_reg  <= '0;
                    den_reg  <= '0;
                    cmp_diff <= '0;
                end
            end
            S_M1:
            begin
                priority if (op_reg == OP_NEG)
                begin
                    // negating the minimum value wraps onto itself
                    ok_reg  <= a_ok_reg && (an_reg != {1'b1, {(W-1){1'b0}}});
                    num_reg <= W'(0) - an_reg;
                    den_reg <= ad_reg;
                end
                else if (op_reg == OP_BAD)
                    ok_reg <= 1'b0;
                else if (op_reg == OP_RCP)
                begin
                    ok_reg  <= a_ok_reg;
                    num_reg <= ad_reg;
                    den_reg <= an_reg;
                end
                else
                    ok_reg <= ok_reg;
            end
            S_W1:
            begin
                if (sdone)
                begin
                    if (pov) ok_reg <= 1'b0;
                    unique case (mi_reg)
                        2'd0:    p_reg <= pval;
                        2'd1:    q_reg <= pval;
                        default: d_reg <= pval;
                    endcase
                    mi_reg <= mi_reg + 2'd1;
                end
            end
            S_SUM:
            begin
                unique case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        if (sov) ok_reg <= 1'b0;
                        num_reg <= sum;
                        den_reg <= d_reg;
                    end
                    OP_CMP:
                    begin
                        if (sov) ok_reg <= 1'b0;
                        cmp_diff <= sum;
                    end
                    default:
                    begin
                        num_reg <= p_reg;
                        den_reg <= q_reg;
                    end
                endcase
            end
            S_CHK:
            begin
                if (den_reg == '0) ok_reg <= 1'b0;
                ga_reg <= mag(num_reg);
                gb_reg <= mag(den_reg);
            end
            S_GW:
            begin
                if (sdone)
                begin
                    ga_reg <= gb_reg;
                    gb_reg <= rem;
                end
            end
            S_DNW:
            begin
                if (sdone) num_reg <= num_reg[W-1] ? (W'(0) - quo) : quo;
            end
            S_DDW:
            begin
                if (sdone) den_reg <= den_reg[W-1] ? (W'(0) - quo) : quo;
            end
            S_FIX:
            begin
                if (den_reg[W-1])
                begin
                    den_reg <= W'(0) - den_reg;
                    num_reg <= W'(0) - num_reg;
                    if (den_reg == {1'b1, {(W-1){1'b0}}} || num_reg == {1'b1, {(W-1){1'b0}}})
                        ok_reg <= 1'b0;
                end
            end
            default: ok_reg <= ok_reg;
        endcase
    end

    assign res_num = (state_reg == S_IDLE && done && op_reg != OP_CMP) ? num_reg : num_reg;
    assign res_den = den_reg;
    assign res_ok  = ok_reg;

    `RAU_ASSERT_NEXT(a_take, clk, rst_n, start && !busy, busy, "request not taken")
    `RAU_ASSERT(a_done_idle, clk, rst_n, done |-> !busy, "done while busy")
    `RAU_ASSERT(a_cmp_zero, clk, rst_n, (done && op_reg == OP_CMP) |-> (res_num == 0 && res_den == 0), "cmp res")
endmodule

[test/rational_arithmetic_unit_tb.sv]
// self-checking testbench for the rational arithmetic unit: directed and random requests
// depends on rau_pkg and the rational_arithmetic_unit rtl
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    typedef struct {
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic               ok;
        logic signed [63:0] diff;
    } frac_res_t;

    localparam longint MAX_CYCLES = 20000000;
    localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    logic [2:0]         op;
    logic signed [63:0] a_num;
    logic signed [63:0] a_den;
    logic               a_ok;
    logic signed [63:0] b_num;
    logic signed [63:0] b_den;
    logic               b_ok;
    logic signed [63:0] res_num;
    logic signed [63:0] res_den;
    logic               res_ok;
    logic signed [63:0] cmp_diff;

    frac_res_t expected_q[$];
    int        n_errors;
    int        n_sent;
    int        n_checked;
    longint    cycle_cnt = 0;
    bit        allow_gaps;

    rational_arithmetic_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .done     (done),
        .op       (op),
        .a_num    (a_num),
        .a_den    (a_den),
        .a_ok     (a_ok),
        .b_num    (b_num),
        .b_den    (b_den),
        .b_ok     (b_ok),
        .res_num  (res_num),
        .res_den  (res_den),
        .res_ok   (res_ok),
        .cmp_diff (cmp_diff)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // golden arithmetic, 64-bit words, overflow clears the ok flag
    // ------------------------------------------------------------------
    function automatic logic [63:0] magnitude(logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // signed product with overflow detection
    function automatic logic [63:0] mul_chk(logic [63:0] a, logic [63:0] b, ref logic ok);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] lim;
        ma  = magnitude(a);
        mb  = magnitude(b);
        lim = (a[63] != b[63]) ? MIN_VAL : MAX_VAL;
        if (ma != 0 && mb > lim / ma)
            ok = 1'b0;
        return a * b;
    endfunction

    function automatic logic [63:0] add_chk(logic [63:0] a, logic [63:0] b, ref logic ok);
        logic [63:0] s;
        s = a + b;
        if (((a ^ s) & (b ^ s)) >> 63)
            ok = 1'b0;
        return s;
    endfunction

    function automatic logic [63:0] sub_chk(logic [63:0] a, logic [63:0] b, ref logic ok);
        logic [63:0] s;
        s = a - b;
        if (((a ^ b) & (a ^ s)) >> 63)
            ok = 1'b0;
        return s;
    endfunction

    // negation of the most negative value wraps onto itself
    function automatic logic [63:0] neg_chk(logic [63:0] x, ref logic ok);
        if (x == MIN_VAL)
            ok = 1'b0;
        return 64'd0 - x;
    endfunction

    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [63:0] div_by_gcd(logic [63:0] x, logic [63:0] g);
        logic [63:0] q;
        q = magnitude(x) / g;
        return x[63] ? (64'd0 - q) : q;
    endfunction

    // gcd reduction and positive denominator; 0/0 stays as it is
    task automatic reduce_frac(ref logic [63:0] num, ref logic [63:0] den, ref logic ok);
        logic [63:0] g;
        if (den == 0)
            ok = 1'b0;
        if (num == 0 && den == 0)
            return;
        g   = euclid_gcd(magnitude(num), magnitude(den));
        num = div_by_gcd(num, g);
        den = div_by_gcd(den, g);
        if (den[63])
        begin
            den = neg_chk(den, ok);
            num = neg_chk(num, ok);
        end
    endtask

    task automatic predict_rational(input logic [2:0] f_op,
                                    input logic [63:0] an, input logic [63:0] ad,
                                    input logic aok,
                                    input logic [63:0] bn, input logic [63:0] bd,
                                    input logic bok, output frac_res_t r);
        logic        ok;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] diff;
        logic [63:0] p;
        logic [63:0] q;
        ok   = aok && bok;
        num  = 0;
        den  = 0;
        diff = 0;
        case (op_t'(f_op))
            OP_ADD, OP_SUB:
            begin
                p   = mul_chk(an, bd, ok);
                q   = mul_chk(bn, ad, ok);
                den = mul_chk(ad, bd, ok);
                num = (op_t'(f_op) == OP_ADD) ? add_chk(p, q, ok) : sub_chk(p, q, ok);
                reduce_frac(num, den, ok);
            end
            OP_MUL:
            begin
                num = mul_chk(an, bn, ok);
                den = mul_chk(ad, bd, ok);
                reduce_frac(num, den, ok);
            end
            OP_DIV:
            begin
                num = mul_chk(an, bd, ok);
                den = mul_chk(ad, bn, ok);
                reduce_frac(num, den, ok);
            end
            OP_CMP:
            begin
                p    = mul_chk(an, bd, ok);
                q    = mul_chk(bn, ad, ok);
                diff = sub_chk(p, q, ok);
            end
            OP_RCP:
            begin
                ok  = aok;
                num = ad;
                den = an;
                reduce_frac(num, den, ok);
            end
            OP_NEG:
            begin
                ok  = aok;
                num = neg_chk(an, ok);
                den = ad;
            end
            default:
                ok = 1'b0;
        endcase
        r.num  = num;
        r.den  = den;
        r.ok   = ok;
        r.diff = diff;
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    task automatic send_request(input logic [2:0] f_op,
                                input logic [63:0] an, input logic [63:0] ad,
                                input logic aok,
                                input logic [63:0] bn, input logic [63:0] bd,
                                input logic bok);
        frac_res_t r;
        int        gap;
        // random idle burst ahead of the request
        if (allow_gaps && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        predict_rational(f_op, an, ad, aok, bn, bd, bok, r);
        op    <= f_op;
        a_num <= an;
        a_den <= ad;
        a_ok  <= aok;
        b_num <= bn;
        b_den <= bd;
        b_ok  <= bok;
        start <= 1'b1;
        // the request is taken at the first edge with busy low
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(r);
        n_sent++;
        start <= 1'b0;
        // let busy rise before the next request looks at it
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result checker: every done pulse is matched against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frac_res_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with no request pending num=%0d den=%0d",
                             $time, res_num, res_den);
                    n_errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    n_checked++;
                    if (res_num !== e.num)
                    begin
                        $display("%0t: res_num expected %0d actual %0d", $time, e.num, res_num);
                        n_errors++;
                    end
                    if (res_den !== e.den)
                    begin
                        $display("%0t: res_den expected %0d actual %0d", $time, e.den, res_den);
                        n_errors++;
                    end
                    if (res_ok !== e.ok)
                    begin
                        $display("%0t: res_ok expected %0b actual %0b", $time, e.ok, res_ok);
                        n_errors++;
                    end
                    if (cmp_diff !== e.diff)
                    begin
                        $display("%0t: cmp_diff expected %0d actual %0d",
                                 $time, e.diff, cmp_diff);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog on the length of the whole run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES)
        begin
            $display("%0t: timeout with %0d results pending", $time, expected_q.size());
            $display("[rational_arithmetic_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // operand generators
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // mostly small values so products stay in range, with some wide ones
    function automatic logic [63:0] rand_operand();
        int unsigned sel;
        logic signed [63:0] v;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: v = 64'($signed($urandom_range(0, 2000)) - 1000);
            4, 5:       v = $signed({32'd0, $urandom()}) - 64'sd2147483648;
            6:          v = rand_word();
            7:          v = $signed(64'(($urandom_range(1, 64)) * 12)) * ($urandom_range(0, 1) ? 1 : -1);
            8:          v = ($urandom_range(0, 1) ? MIN_VAL : MAX_VAL) ^ 64'($urandom_range(0, 3));
            default:    v = 64'($signed($urandom_range(0, 6)) - 3);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------
    task automatic test_directed_ops();
        op_t o;
        // every op, including the unknown code, on ordinary fractions
        for (int i = 0; i < 8; i++)
        begin
            o = op_t'(i);
            send_request(o, 64'sd6, 64'sd4, 1'b1, -64'sd3, 64'sd9, 1'b1);
        end
    endtask

    task automatic test_special_cases();
        // zero over zero stays unreduced
        send_request(OP_MUL, 64'sd0, 64'sd5, 1'b1, 64'sd7, 64'sd0, 1'b1);
        // nonzero over zero reduces to +-1/0
        send_request(OP_RCP, 64'sd0, -64'sd12, 1'b1, 64'sd0, 64'sd1, 1'b1);
        send_request(OP_DIV, 64'sd4, 64'sd3, 1'b1, 64'sd0, 64'sd1, 1'b1);
        // minimum value divided by a power-of-two gcd
        send_request(OP_MUL, MIN_VAL, 64'sd2, 1'b1, 64'sd1, 64'sd1, 1'b1);
        // sign fix-up hits the minimum value
        send_request(OP_RCP, -64'sd1, MIN_VAL, 1'b1, 64'sd0, 64'sd0, 1'b0);
        send_request(OP_RCP, MIN_VAL, 64'sd3, 1'b1, 64'sd0, 64'sd0, 1'b0);
        // negate: min wraps, denominator passes through
        send_request(OP_NEG, MIN_VAL, -64'sd8, 1'b1, MAX_VAL, MAX_VAL, 1'b1);
        send_request(OP_NEG, MAX_VAL, 64'sd0, 1'b0, MIN_VAL, MIN_VAL, 1'b0);
        // product and sum overflow, still reduced
        send_request(OP_MUL, MAX_VAL, 64'sd3, 1'b1, 64'sd2, 64'sd5, 1'b1);
        send_request(OP_ADD, MAX_VAL, 64'sd1, 1'b1, MAX_VAL, 64'sd1, 1'b1);
        send_request(OP_SUB, MIN_VAL, 64'sd1, 1'b1, 64'sd1, 64'sd1, 1'b1);
        // compare overflow and invalid flags
        send_request(OP_CMP, MIN_VAL, 64'sd1, 1'b1, MAX_VAL, 64'sd1, 1'b1);
        send_request(OP_CMP, 64'sd1, 64'sd3, 1'b0, 64'sd1, 64'sd2, 1'b1);
        send_request(OP_ADD, 64'sd1, 64'sd3, 1'b1, 64'sd1, 64'sd2, 1'b0);
        // all-ones and extreme-value patterns
        send_request(OP_ADD, -64'sd1, -64'sd1, 1'b1, -64'sd1, -64'sd1, 1'b1);
        send_request(OP_DIV, MAX_VAL, MIN_VAL, 1'b1, MIN_VAL, MAX_VAL, 1'b1);
    endtask

    task automatic test_random_requests(input int count);
        logic [2:0] f_op;
        for (int i = 0; i < count; i++)
        begin
            // mostly legal ops with valid operands, some unknown op and bad flags
            f_op = ($urandom_range(0, 19) == 0) ? 3'(OP_BAD) : 3'($urandom_range(0, 6));
            send_request(f_op, rand_operand(), rand_operand(), $urandom_range(0, 7) != 0,
                         rand_operand(), rand_operand(), $urandom_range(0, 7) != 0);
        end
    endtask

    // exercises every bit of the wide fields in both states
    task automatic test_wide_patterns();
        logic [63:0] w;
        for (int i = 0; i < 12; i++)
        begin
            w = rand_word();
            send_request(3'($urandom_range(0, 6)), w, ~w, 1'b1, ~w, w, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = '0;
        a_num      = '0;
        a_den      = '0;
        a_ok       = 1'b0;
        b_num      = '0;
        b_den      = '0;
        b_ok       = 1'b0;
        n_errors   = 0;
        n_sent     = 0;
        n_checked  = 0;
        allow_gaps = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_special_cases();
        allow_gaps = 1'b1;
        test_wide_patterns();
        test_random_requests(400);
        // last part of the run without idling
        allow_gaps = 1'b0;
        test_random_requests(80);

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("sent %0d requests over all seven ops plus the unknown code,", n_sent);
        $display("checked %0d results including overflow, zero and minimum-value cases",
                 n_checked);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end
endmodule
